// ===== rtl/packed_pixel_unpack_line_reorder_assert.svh =====
// Assertion macros shared by the pixel unpack / line reorder RTL.
// Included by the modules that check their own logic; needs nothing else.
`ifndef PACKED_PIXEL_UNPACK_LINE_REORDER_ASSERT_SVH
`define PACKED_PIXEL_UNPACK_LINE_REORDER_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define PPUL_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("ppul assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define PPUL_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ppul assertion failed");

`endif

// ===== rtl/ppul_pkg.sv =====
// Shared types and constants for the pixel unpack / line reorder block.
// No dependencies; imported by every module of the block.
package ppul_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int QUEUE_DEPTH    = 4;

    localparam int WORD_W    = 32;
    localparam int PIX_W     = 16;
    localparam int LG_W      = 10;
    localparam int FL_W      = 13;
    localparam int ROW_W     = 12;
    localparam int COL_W_OUT = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int OUT_DAT_W = 56;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PACKED_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_GROUPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LINES = 2'd2;

    localparam logic            PACKED_MODE_RST = 1'b1;
    localparam logic [LG_W-1:0] LINE_GROUPS_RST = 10'd512;
    localparam logic [FL_W-1:0] FRAME_LINES_RST = 13'd4096;

    // One queue entry: one pixel pair, or two when the word closes a packed triple
    typedef struct packed {
        logic             dbl;
        logic [PIX_W-1:0] b1;
        logic [PIX_W-1:0] a1;
        logic [PIX_W-1:0] b0;
        logic [PIX_W-1:0] a0;
    } pair_entry_t;

endpackage

// ===== rtl/ppul_front.sv =====
// Front end: accepts stream words and unpacks them into pixel pair entries.
// Depends on ppul_pkg and the assertion macro header.
module ppul_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         restart,
    input  logic                         packed_mode,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ppul_pkg::WORD_W-1:0]  s_tdata,   // [31:0] stream_word
    input  logic                         q_full,
    output logic                         q_push,
    output ppul_pkg::pair_entry_t        q_entry
);
    import ppul_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [11:0] carry_reg, carry_next;
    logic [3:0]  nib_reg, nib_next;
    logic [WORD_W-1:0] w;

    assign w        = s_tdata;
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_entry    = '0;
        phase_next = phase_reg;
        carry_next = carry_reg;
        nib_next   = nib_reg;
        if (!packed_mode) begin
            q_entry.a0 = w[15:0];
            q_entry.b0 = w[31:16];
            phase_next = PH_FIRST;
        end else begin
            unique case (phase_reg)
                PH_FIRST: begin
                    q_entry.a0 = {4'd0, w[15:4]};
                    q_entry.b0 = {4'd0, w[3:0], w[31:24]};
                    carry_next = {w[23:16], 4'd0};
                    phase_next = PH_SECOND;
                end
                PH_SECOND: begin
                    q_entry.a0 = {4'd0, carry_reg[11:4], w[15:12]};
                    q_entry.b0 = {4'd0, w[11:0]};
                    carry_next = w[31:20];
                    nib_next   = w[19:16];
                    phase_next = PH_THIRD;
                end
                PH_THIRD: begin
                    // close the triple: the carried pair, then the fresh pair
                    q_entry.dbl = 1'b1;
                    q_entry.a0  = {4'd0, carry_reg};
                    q_entry.b0  = {4'd0, nib_reg, w[15:8]};
                    q_entry.a1  = {4'd0, w[7:0], w[31:28]};
                    q_entry.b1  = {4'd0, w[27:16]};
                    phase_next  = PH_FIRST;
                end
                default: begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            phase_reg <= PH_FIRST;
        end else if (q_push) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            carry_reg <= carry_next;
            nib_reg   <= nib_next;
        end
    end

`include "packed_pixel_unpack_line_reorder_assert.svh"
    `PPUL_ASSERT_IMPLY(a_unpacked_phase, aclk, aresetn, !packed_mode, phase_reg == PH_FIRST)

endmodule

// ===== rtl/ppul_fifo.sv =====
// Short queue of pair entries between the front and back ends.
// Depends on ppul_pkg and the assertion macro header.
module ppul_fifo #(
    parameter int DEPTH = ppul_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  flush,
    input  logic                  push,
    input  ppul_pkg::pair_entry_t push_entry,
    output logic                  full,
    output logic                  valid,
    input  logic                  pop,
    output ppul_pkg::pair_entry_t head
);
    import ppul_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    pair_entry_t   mem_reg [DEPTH];
    logic [AW:0]   wr_ptr_reg, rd_ptr_reg;

    assign valid = (wr_ptr_reg != rd_ptr_reg);
    assign full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                   (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign head  = mem_reg[rd_ptr_reg[AW-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= push_entry;
        end
    end

`include "packed_pixel_unpack_line_reorder_assert.svh"
    `PPUL_ASSERT_IMPLY(a_no_push_full, aclk, aresetn, push, !full)
    `PPUL_ASSERT_IMPLY(a_no_pop_empty, aclk, aresetn, pop, valid)

endmodule

// ===== rtl/ppul_back.sv =====
// Back end: places each pixel pair in the frame (row, column, frame end)
// and holds it in the result register. Depends on ppul_pkg and the macro header.
module ppul_back #(
    parameter int MAX_WIDTH  = ppul_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ppul_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            restart,
    input  logic [ppul_pkg::LG_W-1:0]       line_groups,
    input  logic [ppul_pkg::FL_W-1:0]       frame_lines,
    input  logic                            q_valid,
    input  ppul_pkg::pair_entry_t           q_head,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ppul_pkg::OUT_DAT_W-1:0]  m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import ppul_pkg::*;

    localparam int MAXG = MAX_WIDTH / 8;
    localparam int COL_W = $clog2(MAX_WIDTH / 2);
    localparam int H_W   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LP_W  = (MAX_HEIGHT >= 4) ? $clog2(MAX_HEIGHT / 2) : 1;

    // frame geometry from the raw registers
    logic [11:0]      g_clip, g_eff;
    logic [14:0]      h_clip, h_eff;
    logic [COL_W-1:0] last_col;
    logic [LP_W-1:0]  last_lp;
    logic [H_W-1:0]   rows_m1;

    always_comb begin
        g_clip = (line_groups == '0) ? 12'd1 : {2'b00, line_groups};
        g_eff  = (g_clip > 12'(MAXG)) ? 12'(MAXG) : g_clip;
        h_clip = (frame_lines < 13'd2) ? 15'd2 : {2'b00, frame_lines};
        h_eff  = (h_clip > 15'(MAX_HEIGHT)) ? 15'(MAX_HEIGHT) : h_clip;
    end

    assign last_col = COL_W'({g_eff, 2'b00} - 14'd1);
    assign last_lp  = LP_W'((h_eff >> 1) - 15'd1);
    assign rows_m1  = H_W'(h_eff - 15'd1);

    // position state
    logic [COL_W-1:0] col_reg, col_next;
    logic [LP_W-1:0]  lp_reg, lp_next;
    logic             bottom_reg, bottom_next;
    logic             half_reg;
    logic             fend;
    logic [H_W-1:0]   row;

    // result register
    logic                 m_valid_reg;
    logic [PIX_W-1:0]     first_reg, second_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W_OUT-1:0] col_out_reg;
    logic                 fend_reg, last_reg;

    logic load;
    logic run_last;

    assign load     = q_valid && (!m_valid_reg || m_tready);
    assign run_last = !q_head.dbl || half_reg;
    assign q_pop    = load && run_last;
    assign row      = bottom_reg ? (rows_m1 - H_W'(lp_reg)) : H_W'(lp_reg);

    always_comb begin
        col_next    = col_reg + 1'b1;
        lp_next     = lp_reg;
        bottom_next = bottom_reg;
        fend        = 1'b0;
        if (col_reg == last_col) begin
            col_next = '0;
            if (bottom_reg) begin
                bottom_next = 1'b0;
                if (lp_reg == last_lp) begin
                    lp_next = '0;
                    fend    = 1'b1;
                end else begin
                    lp_next = lp_reg + 1'b1;
                end
            end else begin
                bottom_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg    <= '0;
            lp_reg     <= '0;
            bottom_reg <= 1'b0;
            half_reg   <= 1'b0;
        end else if (load) begin
            col_reg    <= col_next;
            lp_reg     <= lp_next;
            bottom_reg <= bottom_next;
            half_reg   <= q_head.dbl && !half_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            first_reg   <= half_reg ? q_head.a1 : q_head.a0;
            second_reg  <= half_reg ? q_head.b1 : q_head.b0;
            row_reg     <= ROW_W'(row);
            col_out_reg <= COL_W_OUT'(col_reg);
            fend_reg    <= fend;
            last_reg    <= run_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, col_out_reg, row_reg, second_reg, first_reg};
    assign m_tlast  = fend_reg;
    assign m_tuser  = last_reg;

`include "packed_pixel_unpack_line_reorder_assert.svh"
    `PPUL_ASSERT_IMPLY(a_frame_end_word_end, aclk, aresetn, m_valid_reg && fend_reg, last_reg)
    `PPUL_ASSERT_IMPLY(a_half_holds_entry, aclk, aresetn, half_reg, q_valid && q_head.dbl)
    `PPUL_ASSERT_ALWAYS(a_col_in_line, aclk, aresetn, col_reg <= last_col)

endmodule

// ===== rtl/packed_pixel_unpack_line_reorder.sv =====
// Top level of the packed pixel unpack / top-bottom line reorder block.
// Depends on ppul_pkg, ppul_front, ppul_fifo and ppul_back.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------------
//  s_       | in        | s_tvalid / s_tready  | s_tdata: stream word
//  m_       | out       | m_tvalid / m_tready  | m_tdata: pixels, row, column; tlast; tuser
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Cycles: one result leaves per cycle from the result register while m_tready
// is high; a word enters per cycle while the four-entry pair queue has room.
// A 16-bit word is one result, so the stream then runs at one word per cycle;
// a packed triple of three words is four results, so packed words are held back
// by the single result port. Words pass the pair queue, then the result register.
// Reset: synchronous, active low; registers return to packed mode, 512 groups,
// 4096 lines, and the frame position returns to the top-left pair.
// Stalls: m_tready low holds the result register; the queue absorbs words
// until full, then s_tready drops. Any write to a defined register restarts
// the frame; the configuration port is always ready.
module packed_pixel_unpack_line_reorder #(
    parameter int MAX_WIDTH  = ppul_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ppul_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ppul_pkg::WORD_W-1:0]      s_tdata,   // [31:0] stream_word
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] pixel_first, [31:16] pixel_second, [43:32] dest_row,
    // [54:44] pair_column, [55] zero
    output logic [ppul_pkg::OUT_DAT_W-1:0]   m_tdata,
    output logic                             m_tlast,   // frame_end
    output logic                             m_tuser,   // [0] run_last
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ppul_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppul_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import ppul_pkg::*;

    logic              packed_mode_reg;
    logic [LG_W-1:0]   line_groups_reg;
    logic [FL_W-1:0]   frame_lines_reg;
    logic              cfg_write;
    logic              restart;

    pair_entry_t       push_entry, q_head;
    logic              q_push, q_full, q_valid, q_pop;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Restart the frame on a write to any defined register; drop other writes.
    always_comb begin
        unique case (cfg_index) inside
            REG_PACKED_MODE,
            REG_LINE_GROUPS,
            REG_FRAME_LINES: restart = cfg_write;
            default:         restart = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packed_mode_reg <= PACKED_MODE_RST;
            line_groups_reg <= LINE_GROUPS_RST;
            frame_lines_reg <= FRAME_LINES_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_PACKED_MODE: packed_mode_reg <= cfg_data[0];
                REG_LINE_GROUPS: line_groups_reg <= cfg_data[LG_W-1:0];
                REG_FRAME_LINES: frame_lines_reg <= cfg_data[FL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: classify words by triple phase and unpack into pair entries.
    ppul_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .restart     (restart),
        .packed_mode (packed_mode_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    // Queue: decouple word intake from result delivery.
    ppul_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .flush      (restart),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .valid      (q_valid),
        .pop        (q_pop),
        .head       (q_head)
    );

    // Back: place each pair in the frame and drive the result transfer.
    ppul_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .restart     (restart),
        .line_groups (line_groups_reg),
        .frame_lines (frame_lines_reg),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== tb/packed_pixel_unpack_line_reorder_tb.sv =====
// Self-checking testbench for packed_pixel_unpack_line_reorder.
// Needs ppul_pkg and the block's RTL; it predicts every pixel pair, row, column
// and end-of-frame flag on its own and checks each result transfer in order.
module packed_pixel_unpack_line_reorder_tb;
    import ppul_pkg::*;

    // Write to this index must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int RANDOM_WORDS = 1076;

    // Position inside a packed triple of stream words
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } triple_phase_t;

    // One expected result transfer, split into its fields
    typedef struct packed {
        logic [PIX_W-1:0]     pix_left;
        logic [PIX_W-1:0]     pix_right;
        logic [ROW_W-1:0]     row;
        logic [COL_W_OUT-1:0] col;
        logic                 frame_end;
        logic                 run_last;
    } pixel_pair_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_DAT_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Register copies as the block should hold them
    logic            mode_packed;
    logic [LG_W-1:0] width_groups;
    logic [FL_W-1:0] height_lines;

    // Frame position as the block should hold it
    triple_phase_t   tri_phase;
    logic [11:0]     carry_pix;
    logic [3:0]      carry_nib;
    int unsigned     col_count;
    int unsigned     line_pair;
    logic            in_bottom;

    pixel_pair_t expected_pairs[$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int words_sent;
    int pairs_checked;
    int frame_ends;
    int reg_writes;

    packed_pixel_unpack_line_reorder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #4000000;
        $display("[packed_pixel_unpack_line_reorder] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Width in groups of eight pixels, clamped to what the block supports
    function automatic int unsigned eff_groups();
        int unsigned g;
        g = width_groups;
        if (g < 1) g = 1;
        if (g > MAX_WIDTH_DEF / 8) g = MAX_WIDTH_DEF / 8;
        return g;
    endfunction

    // Height in lines, clamped to 2..MAX_HEIGHT
    function automatic int unsigned eff_lines();
        int unsigned h;
        h = height_lines;
        if (h < 2) h = 2;
        if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
        return h;
    endfunction

    // Stream words needed for one whole frame under the current registers
    function automatic int unsigned words_per_frame();
        int unsigned pairs;
        pairs = eff_groups() * 4 * (eff_lines() / 2) * 2;
        return mode_packed ? pairs / 4 * 3 : pairs;
    endfunction

    function automatic void restart_position();
        tri_phase = PH_FIRST;
        carry_pix = '0;
        carry_nib = '0;
        col_count = 0;
        line_pair = 0;
        in_bottom = 1'b0;
    endfunction

    // Queue one pixel pair at the current frame position, then advance it
    function automatic void queue_pair(logic [15:0] left, logic [15:0] right, logic last);
        pixel_pair_t p;
        int unsigned h;
        int unsigned row;
        h   = eff_lines();
        row = in_bottom ? h - 1 - line_pair : line_pair;
        p.pix_left  = left;
        p.pix_right = right;
        p.row       = row[ROW_W-1:0];
        p.col       = col_count[COL_W_OUT-1:0];
        p.frame_end = 1'b0;
        p.run_last  = last;
        col_count++;
        if (col_count >= eff_groups() * 4) begin
            col_count = 0;
            tri_phase = PH_FIRST;
            if (in_bottom) begin
                in_bottom = 1'b0;
                line_pair++;
                if (line_pair >= h / 2) begin
                    line_pair   = 0;
                    p.frame_end = 1'b1;
                end
            end else begin
                in_bottom = 1'b1;
            end
        end
        expected_pairs.push_back(p);
    endfunction

    // Unpack one accepted stream word into the pairs it completes
    function automatic void unpack_word(logic [31:0] w);
        if (!mode_packed) begin
            tri_phase = PH_FIRST;
            queue_pair(w[15:0], w[31:16], 1'b1);
        end else begin
            case (tri_phase)
                PH_FIRST: begin
                    carry_pix = {w[23:16], 4'h0};
                    tri_phase = PH_SECOND;
                    queue_pair({4'h0, w[15:4]}, {4'h0, w[3:0], w[31:24]}, 1'b1);
                end
                PH_SECOND: begin
                    logic [15:0] left;
                    left      = {4'h0, carry_pix[11:4], w[15:12]};
                    carry_pix = w[31:20];
                    carry_nib = w[19:16];
                    tri_phase = PH_THIRD;
                    queue_pair(left, {4'h0, w[11:0]}, 1'b1);
                end
                default: begin
                    logic [15:0] left;
                    logic [15:0] right;
                    left      = {4'h0, carry_pix};
                    right     = {4'h0, carry_nib, w[15:8]};
                    tri_phase = PH_FIRST;
                    carry_pix = '0;
                    carry_nib = '0;
                    queue_pair(left, right, 1'b0);
                    queue_pair({4'h0, w[7:0], w[31:28]}, {4'h0, w[27:16]}, 1'b1);
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one stream word; valid stays high into the next call so
    // back-to-back transfers are possible
    task automatic push_word(input logic [31:0] w);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        unpack_word(w);
        words_sent++;
    endtask

    // Drop valid and wait until every predicted pair has been seen
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_pairs.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // Write one register while the block is idle, and mirror it
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] val);
        drain_results();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        reg_writes++;
        case (idx)
            REG_PACKED_MODE: begin
                mode_packed = val[0];
                restart_position();
            end
            REG_LINE_GROUPS: begin
                width_groups = val[LG_W-1:0];
                restart_position();
            end
            REG_FRAME_LINES: begin
                height_lines = val;
                restart_position();
            end
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Mostly random words, with the all-zero and all-one words now and then
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", what);
    endtask

    always @(posedge aclk) begin : check_results
        pixel_pair_t got;
        pixel_pair_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pix_left  = m_tdata[15:0];
            got.pix_right = m_tdata[31:16];
            got.row       = m_tdata[43:32];
            got.col       = m_tdata[54:44];
            got.frame_end = m_tlast;
            got.run_last  = m_tuser;
            if (m_tlast === 1'b1) frame_ends++;
            if (expected_pairs.size() == 0) begin
                note_mismatch($sformatf("pair with nothing pending: %p", got));
            end else begin
                want = expected_pairs.pop_front();
                pairs_checked++;
                if (got !== want || m_tdata[55] !== 1'b0) begin
                    note_mismatch($sformatf("pair %0d exp %p got %p pad %b",
                                            pairs_checked, want, got, m_tdata[55]));
                end
            end
        end
    end

    // Receiver: stall at random at the configured rate
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: packed mode, widest line, tallest frame
    task automatic test_reset_state();
        push_word(32'hFFFF_FFFF);
        push_word(32'h0000_0000);
        push_word(32'hA5C3_3C5A);
    endtask

    // 16-bit pairs with width and height below range: one group, two lines
    task automatic test_pair_mode_low_clamp();
        write_register(REG_PACKED_MODE, 13'h0000);
        write_register(REG_LINE_GROUPS, 13'h0000);
        write_register(REG_FRAME_LINES, 13'h0001);
        push_word(32'h0000_FFFF);
        push_word(32'hFFFF_0000);
        push_word(32'h1234_5678);
        push_word(32'h8000_0001);
        push_word(32'h7FFF_FFFE);
        push_word(32'h55AA_55AA);
        push_word(32'hFFFF_FFFF);
        push_word(32'h0000_0000);
    endtask

    // Odd height: rows 0 and 2 only, the middle row is skipped
    task automatic test_odd_height();
        write_register(REG_PACKED_MODE, 13'h0001);
        write_register(REG_LINE_GROUPS, 13'h0001);
        write_register(REG_FRAME_LINES, 13'h0003);
        repeat (6) push_word($urandom);
    endtask

    // Height above range clamps; the bottom line lands on the last row
    task automatic test_high_clamp();
        write_register(REG_FRAME_LINES, 13'h1FFF);
        repeat (4) push_word($urandom);
    endtask

    // Bad index keeps the triple going; a valid write restarts the frame
    task automatic test_bad_index_and_restart();
        write_register(REG_LINE_GROUPS, 13'h03FF);
        push_word($urandom);
        write_register(REG_NONE, 13'h1FFF);
        push_word($urandom);
        write_register(REG_PACKED_MODE, 13'h1FFF);
        push_word($urandom);
    endtask

    // Random frames: mostly whole frames with small sizes, some cut short,
    // and now and then a wide line that is never finished
    task automatic test_random_frames(input int n_words, input int s_idle, input int r_idle);
        int sent;
        int n;
        int unsigned full;
        logic [CFG_DAT_W-1:0] val;
        drain_results();
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 9) < 7) begin
                val = CFG_DAT_W'($urandom_range(0, 8191));
                write_register(REG_PACKED_MODE, val);
            end
            if ($urandom_range(0, 9) < 7) begin
                val = ($urandom_range(0, 19) == 0) ? CFG_DAT_W'($urandom_range(0, 8191))
                                                   : CFG_DAT_W'($urandom_range(1, 4));
                write_register(REG_LINE_GROUPS, val);
            end
            if ($urandom_range(0, 9) < 7) begin
                val = ($urandom_range(0, 19) == 0) ? CFG_DAT_W'($urandom_range(0, 8191))
                                                   : CFG_DAT_W'($urandom_range(0, 9));
                write_register(REG_FRAME_LINES, val);
            end
            if ($urandom_range(0, 9) == 0) begin
                write_register(REG_NONE, CFG_DAT_W'($urandom_range(0, 8191)));
            end
            full = words_per_frame();
            if (full > 200)                       n = $urandom_range(1, 24);
            else if ($urandom_range(0, 4) == 0)   n = $urandom_range(1, full);
            else                                  n = full;
            if (n > n_words - sent) n = n_words - sent;
            repeat (n) push_word(pick_word());
            sent += n;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_PACKED_MODE;
        cfg_data      = '0;
        send_idle_pct = 35;
        recv_idle_pct = 87;
        mismatches    = 0;
        words_sent    = 0;
        pairs_checked = 0;
        frame_ends    = 0;
        reg_writes    = 0;
        mode_packed   = PACKED_MODE_RST;
        width_groups  = LINE_GROUPS_RST;
        height_lines  = FRAME_LINES_RST;
        restart_position();

        // Hold reset, then release it at a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_pair_mode_low_clamp();
        test_odd_height();
        test_high_clamp();
        test_bad_index_and_restart();

        test_random_frames(RANDOM_WORDS / 3, 35, 87);
        test_random_frames(RANDOM_WORDS / 3, 87, 35);
        test_random_frames(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3), 0, 0);

        // Let the pipeline empty and watch for stray results
        drain_results();
        repeat (20) @(posedge aclk);
        if (expected_pairs.size() != 0) begin
            note_mismatch($sformatf("%0d pairs never arrived", expected_pairs.size()));
        end

        $display("sent %0d stream words in both modes; checked %0d pixel pairs",
                 words_sent, pairs_checked);
        $display("saw %0d frame ends over %0d register writes, %0d mismatches",
                 frame_ends, reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("[packed_pixel_unpack_line_reorder] OK");
        end else begin
            $display("[packed_pixel_unpack_line_reorder] ERROR");
        end
        $finish;
    end

endmodule
